FILE: src/mgkr_pkg.sv
package mgkr_pkg;

  localparam int unsigned REMAP_SIZE  = 54;
  localparam int unsigned SLOT_TAG_W  = 6;
  localparam int unsigned FIFO_DEPTH  = 2;
  localparam int unsigned MOD_W       = 4;

  localparam logic [15:0] TYPE_KEY    = 16'd1;
  localparam logic [15:0] KEY_LCTRL   = 16'd29;
  localparam logic [15:0] KEY_RCTRL   = 16'd97;
  localparam logic [15:0] KEY_LALT    = 16'd56;
  localparam logic [15:0] KEY_WIN     = 16'd125;

  localparam logic [MOD_W-1:0] MOD_LCTRL = 4'b0001;
  localparam logic [MOD_W-1:0] MOD_RCTRL = 4'b0010;
  localparam logic [MOD_W-1:0] MOD_LALT  = 4'b0100;
  localparam logic [MOD_W-1:0] MOD_WIN   = 4'b1000;
  localparam logic [MOD_W-1:0] MOD_NONE  = 4'b0000;

  localparam logic [31:0] VAL_RELEASE = 32'd0;
  localparam logic [31:0] VAL_PRESS   = 32'd1;
  localparam logic [31:0] VAL_REPEAT  = 32'd2;

  localparam logic [5:0] REMAP_TABLE [REMAP_SIZE] = '{
    6'd2,  6'd1,  6'd2,  6'd3,  6'd4,  6'd5,  6'd6,  6'd7,
    6'd8,  6'd9,  6'd10, 6'd11, 6'd9,  6'd41, 6'd14, 6'd15,
    6'd50, 6'd27, 6'd33, 6'd38, 6'd20, 6'd45, 6'd47, 6'd32,
    6'd19, 6'd18, 6'd26, 6'd17, 6'd28, 6'd29, 6'd30, 6'd37,
    6'd23, 6'd53, 6'd51, 6'd52, 6'd25, 6'd48, 6'd24, 6'd39,
    6'd44, 6'd41, 6'd42, 6'd20, 6'd26, 6'd46, 6'd35, 6'd22,
    6'd16, 6'd39, 6'd40, 6'd34, 6'd47, 6'd49
  };

  typedef enum logic [1:0] {
    CMD_PASS,
    CMD_PRESS,
    CMD_RELEASE
  } cmd_kind_e;

  typedef struct packed {
    logic [15:0]        event_type;
    logic [15:0]        key_code;
    logic signed [31:0] event_value;
  } in_req_t;

  typedef struct packed {
    logic [15:0]        out_type;
    logic [15:0]        out_code;
    logic signed [31:0] out_value;
    logic               slots_full;
  } out_rsp_t;

  // classified request handed from front to back
  typedef struct packed {
    in_req_t   req;
    cmd_kind_e kind;
    logic      remappable;
    logic      mod_held;
  } cmd_t;

  function automatic logic [15:0] remap_code(input logic [15:0] code);
    logic [15:0] res;
    res = code;
    if (code < 16'(REMAP_SIZE)) begin
      res = 16'(REMAP_TABLE[code[5:0]]);
    end
    return res;
  endfunction

  function automatic logic [MOD_W-1:0] mod_bit(input logic [15:0] code);
    logic [MOD_W-1:0] res;
    unique case (code)
      KEY_LCTRL: res = MOD_LCTRL;
      KEY_RCTRL: res = MOD_RCTRL;
      KEY_LALT:  res = MOD_LALT;
      KEY_WIN:   res = MOD_WIN;
      default:   res = MOD_NONE;
    endcase
    return res;
  endfunction

  // slot entry is code + 1; only remappable codes (below 54) are stored
  function automatic logic [SLOT_TAG_W-1:0] slot_tag(input logic [15:0] code);
    return code[SLOT_TAG_W-1:0] + SLOT_TAG_W'(1);
  endfunction

endpackage

FILE: src/modifier_gated_key_remapper_unit.sv
// Channel  | Dir | Handshake          | Payload
// ---------+-----+--------------------+------------------------------------
// request  | in  | push / full        | req_i : event_type, key_code, value
// result   | out | empty / pop        | rsp_o : type, code, value, slots_full
//
// One result per request, in order. Pass, repeat, press and ungated
// requests are answered directly from idle in the back end; a gated
// release while N > 0 slots are held sweeps the slot memory, one read a cycle.
// Reset clears the modifier bits and the slot count; the slot memory is
// never used past the count, so it needs no clearing.
// A 2-deep command queue decouples the front from sweeps and pop stalls.
module modifier_gated_key_remapper_unit #(
  parameter int unsigned SLOT_COUNT = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  mgkr_pkg::in_req_t  req_i,
  output logic               empty,
  input  logic               pop,
  output mgkr_pkg::out_rsp_t rsp_o
);
  import mgkr_pkg::*;

  logic fifo_full;
  logic cmd_push, cmd_valid, cmd_pop;
  logic rsp_valid;
  cmd_t cmd_in, cmd_out;

  // front: modifier tracking and request classification
  mgkr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .req_i       (req_i),
    .fifo_full_i (fifo_full),
    .cmd_push_o  (cmd_push),
    .cmd_o       (cmd_in)
  );

  // decouples front from slot sweep
  mgkr_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .cmd_i   (cmd_in),
    .full_o  (fifo_full),
    .pop_i   (cmd_pop),
    .valid_o (cmd_valid),
    .cmd_o   (cmd_out)
  );

  // back: slot list, remap and result register
  mgkr_back #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .rsp_valid_o (rsp_valid),
    .rsp_o       (rsp_o),
    .pop_i       (pop)
  );

  assign full  = fifo_full;
  assign empty = !rsp_valid;

endmodule

FILE: src/mgkr_front.sv
module mgkr_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  mgkr_pkg::in_req_t req_i,
  input  logic             fifo_full_i,
  output logic             cmd_push_o,
  output mgkr_pkg::cmd_t   cmd_o
);
  import mgkr_pkg::*;

  logic [MOD_W-1:0] mask_q, mask_d;
  logic [MOD_W-1:0] mod;
  logic             is_key;
  logic             accept;

  assign accept = push_i && !fifo_full_i;
  assign mod    = mod_bit(req_i.key_code);
  assign is_key = (req_i.event_type == TYPE_KEY) &&
                  ((req_i.event_value == VAL_RELEASE) ||
                   (req_i.event_value == VAL_PRESS) ||
                   (req_i.event_value == VAL_REPEAT));

  always_comb begin
    mask_d = mask_q;
    if (is_key && req_i.event_value == VAL_PRESS) begin
      mask_d = mask_q | mod;
    end else if (is_key && req_i.event_value == VAL_RELEASE) begin
      mask_d = mask_q & ~mod;
    end
  end

  always_comb begin
    cmd_o.req        = req_i;
    cmd_o.remappable = remap_code(req_i.key_code) != req_i.key_code;
    cmd_o.mod_held   = mask_d != MOD_NONE;
    cmd_o.kind       = CMD_PASS;
    if (is_key && req_i.event_value == VAL_PRESS) begin
      cmd_o.kind = CMD_PRESS;
    end else if (is_key && req_i.event_value == VAL_RELEASE) begin
      cmd_o.kind = CMD_RELEASE;
    end
  end

  assign cmd_push_o = accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= MOD_NONE;
    end else if (accept) begin
      mask_q <= mask_d;
    end
  end

endmodule

FILE: src/mgkr_cmd_fifo.sv
module mgkr_cmd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  mgkr_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output mgkr_pkg::cmd_t cmd_o
);
  import mgkr_pkg::*;

  localparam int unsigned PW = $clog2(FIFO_DEPTH);
  localparam int unsigned CW = $clog2(FIFO_DEPTH + 1);

  cmd_t          buf_q [FIFO_DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;
  logic          do_push, do_pop;

  assign full_o  = cnt_q == CW'(FIFO_DEPTH);
  assign valid_o = cnt_q != '0;
  assign cmd_o   = buf_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      buf_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PW'(FIFO_DEPTH - 1)) ? '0 : wr_q + PW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PW'(FIFO_DEPTH - 1)) ? '0 : rd_q + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

endmodule

FILE: src/mgkr_back.sv
module mgkr_back #(
  parameter int unsigned SLOT_COUNT = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  input  mgkr_pkg::cmd_t     cmd_i,
  output logic               cmd_pop_o,
  output logic               rsp_valid_o,
  output mgkr_pkg::out_rsp_t rsp_o,
  input  logic               pop_i
);
  import mgkr_pkg::*;

  localparam int unsigned IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned CW = $clog2(SLOT_COUNT + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_TAIL,
    ST_EMIT
  } state_e;

  logic [SLOT_TAG_W-1:0] slots_q [SLOT_COUNT];
  logic [SLOT_TAG_W-1:0] rd_data_q;

  state_e          state_q, state_d;
  logic [CW-1:0]   count_q, count_d;
  logic [CW-1:0]   last_q, last_d;
  logic [IW-1:0]   idx_q, idx_d;
  logic [IW-1:0]   cmp_idx_q, cmp_idx_d;
  logic            cmp_vld_q, cmp_vld_d;
  logic            matched_q, matched_d;
  in_req_t         cur_q, cur_d;
  logic            rsp_valid_q, rsp_valid_d;
  out_rsp_t        rsp_q, rsp_d;

  logic                  we;
  logic [IW-1:0]         waddr;
  logic [SLOT_TAG_W-1:0] wdata;
  logic                  out_free, gate, fire, press_ok;

  assign out_free = !rsp_valid_q || pop_i;
  assign gate     = cmd_i.remappable && (cmd_i.mod_held || count_q != '0);
  assign fire     = (state_q == ST_IDLE) && cmd_valid_i && out_free;
  assign press_ok = fire && gate && (cmd_i.kind == CMD_PRESS) &&
                    (count_q < CW'(SLOT_COUNT));

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    last_d      = last_q;
    idx_d       = idx_q;
    cmp_idx_d   = idx_q;
    cmp_vld_d   = 1'b0;
    matched_d   = matched_q;
    cur_d       = cur_q;
    rsp_valid_d = rsp_valid_q && !pop_i;
    rsp_d       = rsp_q;
    cmd_pop_o   = 1'b0;
    we          = 1'b0;
    waddr       = idx_q;
    wdata       = '0;

    // compare stage of the release sweep
    if (cmp_vld_q) begin
      if (rd_data_q == slot_tag(cur_q.key_code)) begin
        we        = 1'b1;
        waddr     = cmp_idx_q;
        wdata     = '0;
        matched_d = 1'b1;
      end else if (rd_data_q != '0) begin
        last_d = CW'(cmp_idx_q) + CW'(1);
      end
    end

    unique case (state_q)
      ST_IDLE: begin
        if (fire) begin
          cmd_pop_o = 1'b1;
          if (gate && cmd_i.kind == CMD_RELEASE && count_q != '0) begin
            cur_d     = cmd_i.req;
            matched_d = 1'b0;
            last_d    = '0;
            idx_d     = '0;
            state_d   = ST_SWEEP;
          end else begin
            rsp_valid_d      = 1'b1;
            rsp_d.out_type   = cmd_i.req.event_type;
            rsp_d.out_code   = cmd_i.req.key_code;
            rsp_d.out_value  = cmd_i.req.event_value;
            rsp_d.slots_full = 1'b0;
            if (gate && cmd_i.kind == CMD_PRESS) begin
              if (press_ok) begin
                we             = 1'b1;
                waddr          = count_q[IW-1:0];
                wdata          = slot_tag(cmd_i.req.key_code);
                count_d        = count_q + CW'(1);
                rsp_d.out_code = remap_code(cmd_i.req.key_code);
              end else begin
                rsp_d.slots_full = 1'b1;
              end
            end
          end
        end
      end
      ST_SWEEP: begin
        cmp_vld_d = 1'b1;
        idx_d     = idx_q + IW'(1);
        if (CW'(idx_q) == count_q - CW'(1)) begin
          state_d = ST_TAIL;
        end
      end
      ST_TAIL: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          rsp_valid_d      = 1'b1;
          rsp_d.out_type   = cur_q.event_type;
          rsp_d.out_code   = matched_q ? remap_code(cur_q.key_code) : cur_q.key_code;
          rsp_d.out_value  = cur_q.event_value;
          rsp_d.slots_full = 1'b0;
          count_d          = last_q;
          state_d          = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      slots_q[waddr] <= wdata;
    end
    rd_data_q <= slots_q[idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      last_q      <= '0;
      idx_q       <= '0;
      cmp_idx_q   <= '0;
      cmp_vld_q   <= 1'b0;
      matched_q   <= 1'b0;
      cur_q       <= '0;
      rsp_valid_q <= 1'b0;
      rsp_q       <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      last_q      <= last_d;
      idx_q       <= idx_d;
      cmp_idx_q   <= cmp_idx_d;
      cmp_vld_q   <= cmp_vld_d;
      matched_q   <= matched_d;
      cur_q       <= cur_d;
      rsp_valid_q <= rsp_valid_d;
      rsp_q       <= rsp_d;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(SLOT_COUNT))
    else $error("held slot count beyond slot list");

  a_sweep_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> (count_q != '0))
    else $error("release sweep with empty slot list");

  a_press_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    press_ok |=> (count_q == $past(count_q) + CW'(1)))
    else $error("recorded press did not grow slot list");

  a_sweep_no_trailing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && out_free) |=> (count_q <= $past(count_q)))
    else $error("release sweep grew slot list");
`endif

endmodule
